FILE: hdl/pf_pkg.sv
// pf_pkg: shared types, codes and square arithmetic for the Playfair encryptor.
// No dependencies; imported by every module of the block.
`default_nettype none

package pf_pkg;

  // Square geometry and special letters (index 0 = 'A')
  localparam int SIDE    = 5;
  localparam int CELLS   = SIDE * SIDE;
  localparam int LETTERS = 26;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);
  localparam logic [4:0] FULL_COUNT  = 5'(CELLS);

  // ASCII bases
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

  // Input function codes
  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_KEY   = 3'd1;
  localparam logic [2:0] FUNC_DONE  = 3'd2;
  localparam logic [2:0] FUNC_TEXT  = 3'd3;
  localparam logic [2:0] FUNC_END   = 3'd4;

  // Command queue geometry
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Classified command passed from front to back
  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_KEY   = 3'd1,
    OP_DONE  = 3'd2,
    OP_TEXT  = 3'd3,
    OP_END   = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [4:0] letter;
  } cmd_t;

  // Row of a cell index 0..24
  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p < 5'd5)       r = 3'd0;
    else if (p < 5'd10) r = 3'd1;
    else if (p < 5'd15) r = 3'd2;
    else if (p < 5'd20) r = 3'd3;
    else                r = 3'd4;
    return r;
  endfunction

  // Column of a cell index 0..24
  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] q;
    q = p - 5'(SIDE) * 5'(pos_row(p));
    return q[2:0];
  endfunction

  // Step one place along a row or column, wrapping
  function automatic logic [2:0] inc5(input logic [2:0] x);
    return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return 5'(r) * 5'(SIDE) + 5'(c);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/pf_front.sv
// pf_front: normalizes raw bytes and classifies each input item into a command.
// Depends on pf_pkg.
`default_nettype none

module pf_front import pf_pkg::*; (
  input  wire logic [2:0] func,
  input  wire logic [7:0] char_in,
  output cmd_t            cmd,
  output logic            keep
);

  logic       is_letter;
  logic [4:0] letter;
  logic [7:0] offs;

  // Fold case, J to I; flag non-letters
  always_comb begin
    offs      = 8'd0;
    is_letter = 1'b0;
    if (char_in >= ASCII_LOWER_A && char_in <= ASCII_LOWER_Z) begin
      offs      = char_in - ASCII_LOWER_A;
      is_letter = 1'b1;
    end else if (char_in >= ASCII_UPPER_A && char_in <= ASCII_UPPER_Z) begin
      offs      = char_in - ASCII_UPPER_A;
      is_letter = 1'b1;
    end
    letter = (offs[4:0] == LETTER_J) ? LETTER_I : offs[4:0];
  end

  // Items that cannot change state are dropped here
  always_comb begin
    cmd.letter = letter;
    cmd.op     = OP_CLEAR;
    keep       = 1'b0;
    case (func)
      FUNC_CLEAR: begin
        cmd.op = OP_CLEAR;
        keep   = 1'b1;
      end
      FUNC_KEY: begin
        cmd.op = OP_KEY;
        keep   = is_letter;
      end
      FUNC_DONE: begin
        cmd.op = OP_DONE;
        keep   = 1'b1;
      end
      FUNC_TEXT: begin
        cmd.op = OP_TEXT;
        keep   = is_letter;
      end
      FUNC_END: begin
        cmd.op = OP_END;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/pf_cmd_queue.sv
// pf_cmd_queue: short FIFO of commands between front and back.
// Depends on pf_pkg.
`default_nettype none

module pf_cmd_queue import pf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  cmd_t                 entries [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr;
  logic [CMDQ_AW-1:0]   rd_ptr;
  logic [CMDQ_AW:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + CMDQ_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + CMDQ_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (CMDQ_AW+1)'(1);
        2'b01:   count <= count - (CMDQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pf_back.sv
// pf_back: key square build, pairing and pair encipherment, with result FIFO.
// Depends on pf_pkg.
`default_nettype none

module pf_back import pf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_empty,
  input  wire cmd_t       cmd,
  output logic            cmd_pop,
  input  wire logic       res_pop,
  output logic            res_empty,
  output logic [6:0]      cipher_char,
  output logic            last_of_run
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FILL  = 5'b00010,
    S_POS   = 5'b00100,
    S_EMIT1 = 5'b01000,
    S_EMIT2 = 5'b10000
  } state_t;

  state_t state, state_next;

  // Key square stores
  logic [4:0]         square_letter   [CELLS];
  logic [4:0]         letter_position [LETTERS];
  logic [LETTERS-1:0] letter_used;
  logic [4:0]         fill_count;
  logic [4:0]         pending_letter;
  logic               pending_valid;
  logic [4:0]         fill_iter;

  // Read data registers
  logic [4:0] pos_a, pos_b;
  logic [4:0] sq_a, sq_b;

  // Result FIFO
  logic [4:0] res_letter [2];
  logic       res_last   [2];
  logic       res_wr, res_rd;
  logic [1:0] res_count;
  logic       res_push;
  logic       res_push_last;
  logic [4:0] res_push_letter;
  logic       res_do_pop;

  // Control decoded from the popped command and the fill sweep
  logic       take;
  logic       pair_go;
  logic [4:0] pair_a, pair_b;
  logic       place_en;
  logic [4:0] place_idx;
  logic       sq_full;

  // Cell arithmetic for the pair
  logic [2:0] r1, c1, r2, c2;
  logic [4:0] o1, o2;

  assign sq_full = (fill_count == FULL_COUNT);
  assign take    = (state == S_IDLE) && !cmd_empty;
  assign cmd_pop = take;

  // Decide what the popped command does
  always_comb begin
    pair_go   = 1'b0;
    pair_a    = cmd.letter;
    pair_b    = LETTER_X;
    place_en  = 1'b0;
    place_idx = cmd.letter;
    if (state == S_FILL) begin
      place_idx = fill_iter;
      place_en  = (fill_iter != LETTER_J);
    end else if (take) begin
      case (cmd.op)
        OP_KEY: begin
          place_en = 1'b1;
        end
        OP_TEXT: begin
          if (sq_full && pending_valid) begin
            pair_go = 1'b1;
            if (pending_letter != cmd.letter) begin
              pair_a = pending_letter;
              pair_b = cmd.letter;
            end
          end
        end
        OP_END: begin
          if (pending_valid) begin
            pair_go = 1'b1;
            pair_a  = pending_letter;
          end
        end
        default: begin
          pair_go = 1'b0;
        end
      endcase
    end
    if (fill_count >= FULL_COUNT || letter_used[place_idx]) begin
      place_en = 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take && cmd.op == OP_DONE) state_next = S_FILL;
        else if (pair_go)              state_next = S_POS;
      end
      S_FILL: begin
        if (fill_iter == LAST_LETTER) state_next = S_IDLE;
      end
      S_POS: begin
        state_next = S_EMIT1;
      end
      S_EMIT1: begin
        if (res_push) state_next = S_EMIT2;
      end
      S_EMIT2: begin
        if (res_push) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      letter_used   <= '0;
      fill_count    <= '0;
      pending_letter <= '0;
      pending_valid <= 1'b0;
      fill_iter     <= '0;
    end else begin
      state <= state_next;
      if (take && cmd.op == OP_DONE) begin
        fill_iter <= '0;
      end else if (state == S_FILL) begin
        fill_iter <= fill_iter + 5'd1;
      end
      if (take && cmd.op == OP_CLEAR) begin
        letter_used    <= '0;
        fill_count     <= '0;
        pending_letter <= '0;
        pending_valid  <= 1'b0;
      end else if (place_en) begin
        letter_used[place_idx] <= 1'b1;
        fill_count             <= fill_count + 5'd1;
      end
      // Pairing: an open pair closes unless the letter repeats
      if (take && cmd.op == OP_TEXT && sq_full) begin
        if (!pending_valid) begin
          pending_letter <= cmd.letter;
          pending_valid  <= 1'b1;
        end else if (pending_letter != cmd.letter) begin
          pending_valid <= 1'b0;
        end
      end
      if (take && cmd.op == OP_END) begin
        pending_valid <= 1'b0;
      end
    end
  end

  // Letter placement writes
  always_ff @(posedge clk) begin
    if (place_en) begin
      square_letter[fill_count]  <= place_idx;
      letter_position[place_idx] <= fill_count;
    end
  end

  // Position lookup of both letters
  always_ff @(posedge clk) begin
    if (pair_go) begin
      pos_a <= letter_position[pair_a];
      pos_b <= letter_position[pair_b];
    end
  end

  // Row, column and rectangle rules
  always_comb begin
    r1 = pos_row(pos_a);
    c1 = pos_col(pos_a);
    r2 = pos_row(pos_b);
    c2 = pos_col(pos_b);
    if (r1 == r2) begin
      o1 = cell_of(r1, inc5(c1));
      o2 = cell_of(r2, inc5(c2));
    end else if (c1 == c2) begin
      o1 = cell_of(inc5(r1), c1);
      o2 = cell_of(inc5(r2), c2);
    end else begin
      o1 = cell_of(r1, c2);
      o2 = cell_of(r2, c1);
    end
  end

  // Cipher letter lookup
  always_ff @(posedge clk) begin
    if (state == S_POS) begin
      sq_a <= square_letter[o1];
      sq_b <= square_letter[o2];
    end
  end

  // Result FIFO: two entries
  assign res_push        = (state == S_EMIT1 || state == S_EMIT2) && (res_count != 2'd2);
  assign res_push_last   = (state == S_EMIT2);
  assign res_push_letter = res_push_last ? sq_b : sq_a;
  assign res_empty       = (res_count == 2'd0);
  assign res_do_pop      = res_pop && !res_empty;
  assign cipher_char     = 7'(ASCII_UPPER_A) + {2'b00, res_letter[res_rd]};
  assign last_of_run     = res_last[res_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_letter[res_wr] <= res_push_letter;
      res_last[res_wr]   <= res_push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= 1'b0;
      res_rd    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (res_push)   res_wr <= ~res_wr;
      if (res_do_pop) res_rd <= ~res_rd;
      case ({res_push, res_do_pop})
        2'b10:   res_count <= res_count + 2'd1;
        2'b01:   res_count <= res_count - 2'd1;
        default: res_count <= res_count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/playfair_encrypt.sv
// playfair_encrypt: top level, front classifier, command queue and back end.
// Depends on pf_pkg, pf_front, pf_cmd_queue, pf_back.
//
//   channel  | handshake       | payload
//   ---------+-----------------+---------------------------
//   input    | push / full     | func[2:0], char_in[7:0]
//   result   | pop / empty     | cipher_char[6:0], last_of_run
//
// Clear, key byte and a text byte that opens a pair are taken in the back end without leaving idle.
// Non-letter key/text bytes and unused funcs are dropped at the front.
// A text or end item that closes a pair: position read, cell read, two results (stalls while result FIFO is full).
// Key done: one alphabet letter per cycle over the fill sweep.
// A four-entry command queue lets input keep flowing while a pair is enciphered.
// Synchronous reset empties both queues, the used-letter flags and the open pair.
`default_nettype none

module playfair_encrypt import pf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] func,
  input  wire logic [7:0] char_in,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      cipher_char,
  output logic            last_of_run
);

  cmd_t front_cmd;
  logic front_keep;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;

  pf_front u_front (
    .func    (func),
    .char_in (char_in),
    .cmd     (front_cmd),
    .keep    (front_keep)
  );

  pf_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push && front_keep),
    .push_data (front_cmd),
    .full      (full),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .empty     (q_empty)
  );

  pf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (q_empty),
    .cmd         (q_cmd),
    .cmd_pop     (q_pop),
    .res_pop     (pop),
    .res_empty   (empty),
    .cipher_char (cipher_char),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
